### rtl/tss_pkg.sv
// ============================================================================
// tss_pkg
// Shared types and codes for the three-stacks shared-memory block.
// ============================================================================
`default_nettype none

package tss_pkg;

    // Default sizes; the top level takes them as parameter defaults.
    localparam int DEF_STORE_DEPTH = 64;
    localparam int DEF_WORD_BITS   = 32;

    // Request kinds.
    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    // Stack selectors.
    localparam logic [1:0] SEL_A = 2'd0;
    localparam logic [1:0] SEL_B = 2'd1;
    localparam logic [1:0] SEL_C = 2'd2;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LEFT     = 3'd1,
        ST_RIGHT    = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_BAD      = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]          mode;
        logic [1:0]          stack_sel;
        logic signed [31:0]  push_value;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic signed [31:0]  top_value;
    } t_rsp;

endpackage : tss_pkg

`default_nettype wire

### rtl/tss_ifs.sv
// ============================================================================
// tss_req_if / tss_rsp_if
// Valid/ready channel interfaces for requests and responses.
// ============================================================================
`default_nettype none

interface tss_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [1:0]         stack_sel;
    logic signed [31:0] push_value;

    modport source (output valid, output mode, output stack_sel, output push_value,
                    input ready);
    modport sink   (input valid, input mode, input stack_sel, input push_value,
                    output ready);
endinterface : tss_req_if

interface tss_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] top_value;

    modport source (output valid, output status, output top_value, input ready);
    modport sink   (input valid, input status, input top_value, output ready);
endinterface : tss_rsp_if

`default_nettype wire

### rtl/tss_ram.sv
// ============================================================================
// tss_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
`default_nettype none

module tss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : tss_ram

`default_nettype wire

### rtl/tss_seq.sv
// ============================================================================
// tss_seq
// Request sequencer: stack pointers, fill counts, and the read-modify-write
// walk over the shared memory, including the one-entry move of stack B.
// ============================================================================
`default_nettype none

module tss_seq #(
    parameter int STORE_DEPTH = 64,
    parameter int WORD_BITS   = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_req_valid,
    output logic                                o_req_ready,
    input  wire tss_pkg::t_req                  i_req,
    output logic                                o_ram_we,
    output logic [$clog2(STORE_DEPTH)-1:0]      o_ram_waddr,
    output logic [WORD_BITS-1:0]                o_ram_wdata,
    output logic                                o_ram_re,
    output logic [$clog2(STORE_DEPTH)-1:0]      o_ram_raddr,
    input  wire logic [WORD_BITS-1:0]           i_ram_rdata,
    output logic                                o_res_valid,
    input  wire logic                           i_res_ready,
    output tss_pkg::t_rsp                       o_res
);
    import tss_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    // Pointers range from -1 to STORE_DEPTH, so they carry a sign bit.
    localparam int PW = CW + 1;

    localparam logic signed [PW-1:0] ZERO    = '0;
    localparam logic signed [PW-1:0] ONE     = 1;
    localparam logic signed [PW-1:0] DEPTH_S = PW'(STORE_DEPTH);
    localparam logic signed [PW-1:0] BASE_B0 = PW'(STORE_DEPTH / 3);
    localparam logic signed [PW-1:0] TOP_C0  = PW'(STORE_DEPTH - 1);
    localparam logic [CW+1:0]        FULL_N  = (CW + 2)'(STORE_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_DECIDE    = 8'b0000_0010,
        S_SHIFT_RD  = 8'b0000_0100,
        S_SHIFT_WR  = 8'b0000_1000,
        S_PUSH      = 8'b0001_0000,
        S_PEEK_RD   = 8'b0010_0000,
        S_PEEK_DATA = 8'b0100_0000,
        S_DONE      = 8'b1000_0000
    } t_state;

    t_state                r_state,     n_state;
    logic signed [PW-1:0]  r_top_a,     n_top_a;
    logic signed [PW-1:0]  r_base_b,    n_base_b;
    logic signed [PW-1:0]  r_top_b,     n_top_b;
    logic signed [PW-1:0]  r_top_c,     n_top_c;
    logic [CW-1:0]         r_cnt_a,     n_cnt_a;
    logic [CW-1:0]         r_cnt_b,     n_cnt_b;
    logic [CW-1:0]         r_cnt_c,     n_cnt_c;
    logic [1:0]            r_mode,      n_mode;
    logic [1:0]            r_sel,       n_sel;
    logic [WORD_BITS-1:0]  r_val,       n_val;
    logic signed [PW-1:0]  r_idx,       n_idx;
    logic                  r_right,     n_right;
    t_status               r_status,    n_status;
    logic signed [31:0]    r_top_value, n_top_value;

    logic signed [63:0]    req_ext;
    logic signed [63:0]    rd_ext;
    logic [CW+1:0]         used;
    logic                  full;
    logic [CW-1:0]         sel_cnt;
    logic signed [PW-1:0]  push_at;
    logic signed [PW-1:0]  peek_at;
    logic signed [PW-1:0]  b_last;
    logic signed [PW-1:0]  wr_idx;

    // Words are stored at WORD_BITS and come back sign-extended to 32 bits.
    assign req_ext = 64'($signed(i_req.push_value));
    assign rd_ext  = 64'($signed(i_ram_rdata));

    assign used   = (CW + 2)'(r_cnt_a) + (CW + 2)'(r_cnt_b) + (CW + 2)'(r_cnt_c);
    assign full   = (used >= FULL_N);
    assign b_last = r_top_b - ONE;

    always_comb begin
        case (r_sel)
            SEL_A:   begin sel_cnt = r_cnt_a; push_at = r_top_a; peek_at = r_top_a - ONE; end
            SEL_B:   begin sel_cnt = r_cnt_b; push_at = r_top_b; peek_at = r_top_b - ONE; end
            SEL_C:   begin sel_cnt = r_cnt_c; push_at = r_top_c; peek_at = r_top_c + ONE; end
            default: begin sel_cnt = '0;      push_at = ZERO;    peek_at = ZERO;          end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_top_a     = r_top_a;
        n_base_b    = r_base_b;
        n_top_b     = r_top_b;
        n_top_c     = r_top_c;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_cnt_c     = r_cnt_c;
        n_mode      = r_mode;
        n_sel       = r_sel;
        n_val       = r_val;
        n_idx       = r_idx;
        n_right     = r_right;
        n_status    = r_status;
        n_top_value = r_top_value;
        wr_idx      = r_idx;
        o_ram_we    = 1'b0;
        o_ram_wdata = i_ram_rdata;
        o_ram_re    = 1'b0;
        o_ram_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_mode  = i_req.mode;
                    n_sel   = i_req.stack_sel;
                    n_val   = req_ext[WORD_BITS-1:0];
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_status    = ST_OK;
                n_top_value = '0;
                if (!(r_sel inside {SEL_A, SEL_B, SEL_C}) ||
                    !(r_mode inside {MODE_PUSH, MODE_POP, MODE_PEEK})) begin
                    n_status = ST_BAD;
                    n_state  = S_DONE;
                end else if (r_mode == MODE_PUSH) begin
                    if (full) begin
                        n_status = ST_OVERFLOW;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_PUSH;
                        case (r_sel)
                            SEL_A: begin
                                if (r_top_a >= r_base_b) begin
                                    n_status = ST_RIGHT;
                                    n_right  = 1'b1;
                                    n_idx    = r_top_b;
                                    n_state  = S_SHIFT_RD;
                                end
                            end
                            SEL_B: begin
                                if (r_top_b > r_top_c) begin
                                    n_status = ST_LEFT;
                                    n_right  = 1'b0;
                                    n_idx    = r_base_b - ONE;
                                    n_state  = S_SHIFT_RD;
                                end
                            end
                            default: begin
                                if (r_top_c < r_top_b) begin
                                    n_status = ST_LEFT;
                                    n_right  = 1'b0;
                                    n_idx    = r_base_b - ONE;
                                    n_state  = S_SHIFT_RD;
                                end
                            end
                        endcase
                    end
                end else if (sel_cnt == '0) begin
                    n_status = ST_EMPTY;
                    n_state  = S_DONE;
                end else if (r_mode == MODE_POP) begin
                    n_state = S_DONE;
                    case (r_sel)
                        SEL_A: begin
                            n_top_a = r_top_a - ONE;
                            n_cnt_a = r_cnt_a - CW'(1);
                        end
                        SEL_B: begin
                            n_top_b = r_top_b - ONE;
                            n_cnt_b = r_cnt_b - CW'(1);
                        end
                        default: begin
                            n_top_c = r_top_c + ONE;
                            n_cnt_c = r_cnt_c - CW'(1);
                        end
                    endcase
                end else begin
                    n_state = S_PEEK_RD;
                end
            end
            S_SHIFT_RD: begin
                // Fetch the neighbor of the entry about to be overwritten.
                if (r_right ? (r_idx > r_base_b) : (r_idx < b_last)) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = r_right ? AW'(r_idx - ONE) : AW'(r_idx + ONE);
                    n_state     = S_SHIFT_WR;
                end else begin
                    if (r_right) begin
                        n_base_b = r_base_b + ONE;
                        n_top_b  = r_top_b + ONE;
                    end else begin
                        n_base_b = r_base_b - ONE;
                        n_top_b  = r_top_b - ONE;
                    end
                    n_state = S_PUSH;
                end
            end
            S_SHIFT_WR: begin
                wr_idx      = r_idx;
                o_ram_we    = (r_idx >= ZERO) && (r_idx < DEPTH_S);
                o_ram_wdata = i_ram_rdata;
                n_idx       = r_right ? (r_idx - ONE) : (r_idx + ONE);
                n_state     = S_SHIFT_RD;
            end
            S_PUSH: begin
                wr_idx      = push_at;
                o_ram_we    = (push_at >= ZERO) && (push_at < DEPTH_S);
                o_ram_wdata = r_val;
                n_state     = S_DONE;
                case (r_sel)
                    SEL_A: begin
                        n_top_a = r_top_a + ONE;
                        n_cnt_a = r_cnt_a + CW'(1);
                    end
                    SEL_B: begin
                        n_top_b = r_top_b + ONE;
                        n_cnt_b = r_cnt_b + CW'(1);
                    end
                    default: begin
                        n_top_c = r_top_c - ONE;
                        n_cnt_c = r_cnt_c + CW'(1);
                    end
                endcase
            end
            S_PEEK_RD: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = peek_at[AW-1:0];
                n_state     = S_PEEK_DATA;
            end
            S_PEEK_DATA: begin
                n_top_value = rd_ext[31:0];
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ram_waddr = wr_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_top_a  <= ZERO;
            r_base_b <= BASE_B0;
            r_top_b  <= BASE_B0;
            r_top_c  <= TOP_C0;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_cnt_c  <= '0;
        end else begin
            r_state  <= n_state;
            r_top_a  <= n_top_a;
            r_base_b <= n_base_b;
            r_top_b  <= n_top_b;
            r_top_c  <= n_top_c;
            r_cnt_a  <= n_cnt_a;
            r_cnt_b  <= n_cnt_b;
            r_cnt_c  <= n_cnt_c;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_sel       <= n_sel;
        r_val       <= n_val;
        r_idx       <= n_idx;
        r_right     <= n_right;
        r_status    <= n_status;
        r_top_value <= n_top_value;
    end

    assign o_req_ready     = (r_state == S_IDLE);
    assign o_res_valid     = (r_state == S_DONE);
    assign o_res.status    = r_status;
    assign o_res.top_value = r_top_value;

endmodule : tss_seq

`default_nettype wire

### rtl/tss_out_reg.sv
// ============================================================================
// tss_out_reg
// Output register that holds a finished response until the receiver takes it.
// ============================================================================
`default_nettype none

module tss_out_reg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire tss_pkg::t_rsp  i_rsp,
    tss_rsp_if.source           o_rsp
);
    import tss_pkg::*;

    logic r_valid, n_valid;
    t_rsp r_rsp;

    assign o_ready = !r_valid || o_rsp.ready;
    assign n_valid = o_ready ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_rsp.valid     = r_valid;
    assign o_rsp.status    = r_rsp.status;
    assign o_rsp.top_value = r_rsp.top_value;

endmodule : tss_out_reg

`default_nettype wire

### rtl/three_stacks_shared_memory.sv
// ============================================================================
// three_stacks_shared_memory
// Three stacks (A up from entry 0, B up from a movable base, C down from the
// last entry) kept in one shared synchronous word memory.
// ============================================================================
// Usage:
//   i_req carries one request per transaction: mode (push, pop, peek top),
//   stack_sel (A, B, C) and push_value. o_rsp returns exactly one response
//   transaction per request with a status code and, for a successful peek,
//   the top word sign-extended to 32 bits; every other response carries zero.
//   Requests are handled one at a time. After the accepting edge each request
//   passes the decide state; a pop, empty or rejected request then completes,
//   a push first writes its word, and a peek first reads the top entry and
//   captures the word. A push that must move stack B by one entry first
//   copies every word held in B, each moved word needing one read and one
//   write of the memory. i_req.ready rises at the same edge that hands the
//   response to the output register, so no new request is taken before the
//   last one has been handed over.
//   The response sits in an output register; while the receiver stalls, the
//   block still takes and works on the next request, and only holds it at
//   completion until the register frees up.
//   Reset is synchronous and active low. It empties all three stacks and
//   puts stack B back at one third of the memory; the memory contents are
//   not cleared, and no request can read an entry that was never written.
// ============================================================================
`default_nettype none

module three_stacks_shared_memory #(
    parameter int STORE_DEPTH = tss_pkg::DEF_STORE_DEPTH,
    parameter int WORD_BITS   = tss_pkg::DEF_WORD_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tss_req_if.sink    i_req,
    tss_rsp_if.source  o_rsp
);
    import tss_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);

    // Request payload packed for the sequencer.
    t_req                 req;

    // Memory port between the sequencer and the word store.
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    // Finished response handed to the output register.
    logic                 res_valid;
    logic                 res_ready;
    t_rsp                 res;

    assign req.mode       = i_req.mode;
    assign req.stack_sel  = i_req.stack_sel;
    assign req.push_value = i_req.push_value;

    // The sequencer owns all pointers and counts and drives every memory
    // access, so reads and writes to one entry never overlap.
    tss_seq #(
        .STORE_DEPTH (STORE_DEPTH),
        .WORD_BITS   (WORD_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (req),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // The shared word store for all three stacks.
    tss_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Output register decoupling the receiver from the sequencer.
    tss_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_rsp   (res),
        .o_rsp   (o_rsp)
    );

endmodule : three_stacks_shared_memory

`default_nettype wire

### rtl/tss_checker.sv
// ============================================================================
// tss_checker
// Port-level checks for the three-stacks block, bound to the top level.
// ============================================================================
`default_nettype none

module tss_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_req_valid,
    input wire logic               i_req_ready,
    input wire logic               i_rsp_valid,
    input wire logic               i_rsp_ready,
    input wire logic [2:0]         i_rsp_status,
    input wire logic signed [31:0] i_rsp_top_value
);
    import tss_pkg::*;

    // Reset drops any pending response.
    a_reset_clears_rsp: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // Requests are taken one at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while one is in progress");

    // Only a successful peek returns a word.
    a_value_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_top_value != 32'sd0) |-> i_rsp_status == ST_OK)
        else $error("nonzero top value with non-ok status");

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_top_value))
        else $error("stalled response changed");

endmodule : tss_checker

bind three_stacks_shared_memory tss_checker u_tss_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_status    (o_rsp.status),
    .i_rsp_top_value (o_rsp.top_value)
);

`default_nettype wire
